// ===== rtl/crg_pkg.sv =====
// Shared widths, codes and pipeline payload types for the camera ray generator.
`timescale 1ns / 1ps
package crg_pkg;

   localparam int PIXEL_COORD_BITS = 12;
   localparam int DIR_FRAC_BITS    = 14;

   localparam int ROW_W      = 64;
   localparam int COEF_W     = 16;
   localparam int TRANS_LSB  = 48;
   localparam int HALF_W     = 16;
   localparam int PS_W       = 24;
   localparam int OUT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // half is Q4.12, canvas point is Q.25; -1.0 in Q.25 for the z term
   localparam int HALF_SHIFT = 13;
   localparam int Z_SHIFT    = 25;

   // canvas offset (2p+1)*pitch and the signed canvas coordinate
   localparam int OFF_W  = PIXEL_COORD_BITS + 1 + PS_W;
   localparam int W_W    = OFF_W + 1;
   localparam int PROD_W = W_W + COEF_W;
   localparam int D_W    = PROD_W + 2;
   localparam int MAG_W  = D_W;

   // leading-one search in groups of eight bits
   localparam int GRP_N  = (MAG_W + 7) / 8;
   localparam int PAD_W  = GRP_N * 8;
   localparam int POS_W  = $clog2(PAD_W);

   // block scaling puts the largest magnitude in [2^29, 2^30)
   localparam int NORM_MSB = 29;
   localparam int NM_W     = NORM_MSB + 1;
   localparam int SQ_W     = 2 * NM_W;
   localparam int SUM_W    = SQ_W + 2;
   localparam int ROOT_W   = SUM_W / 2;
   localparam int EXT_W    = SUM_W + 2;

   // rounding divide: quotient never exceeds 2^F
   localparam int Q_W   = DIR_FRAC_BITS + 1;
   localparam int DIV_W = ROOT_W + DIR_FRAC_BITS + 1;
   localparam int QX_W  = 32;
   localparam logic [Q_W-1:0] DIR_ONE = Q_W'(1) << DIR_FRAC_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X       = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Z       = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HEIGHT = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_SIZE  = CSR_IDX_W'(5);

   localparam logic [ROW_W-1:0]  ROW_X_RESET = 64'h0000_0000_0000_1000;
   localparam logic [ROW_W-1:0]  ROW_Y_RESET = 64'h0000_0000_1000_0000;
   localparam logic [ROW_W-1:0]  ROW_Z_RESET = 64'h0000_1000_0000_0000;
   localparam logic [HALF_W-1:0] HALF_RESET  = 16'd4096;
   localparam logic [PS_W-1:0]   PS_RESET    = 24'd335544;

   typedef struct packed {
      logic                        valid;
      logic [2:0]                  neg;
      logic [2:0][MAG_W-1:0]       mag;
   } front_type;

   typedef struct packed {
      logic                        valid;
      logic                        deg;
      logic [2:0]                  neg;
      logic [2:0][NM_W-1:0]        m;
   } side_type;

   typedef struct packed {
      logic                        valid;
      logic                        deg;
      logic [2:0][OUT_W-1:0]       dir;
   } rsp_type;

endpackage

// ===== rtl/crg_front.sv =====
// Canvas point, inverse transform and component magnitudes (four stages).
`timescale 1ns / 1ps
module crg_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic [crg_pkg::PIXEL_COORD_BITS-1:0] px,
   input  logic [crg_pkg::PIXEL_COORD_BITS-1:0] py,
   input  logic [crg_pkg::ROW_W-1:0]            row_x,
   input  logic [crg_pkg::ROW_W-1:0]            row_y,
   input  logic [crg_pkg::ROW_W-1:0]            row_z,
   input  logic [crg_pkg::HALF_W-1:0]           half_w,
   input  logic [crg_pkg::HALF_W-1:0]           half_h,
   input  logic [crg_pkg::PS_W-1:0]             ps,
   output crg_pkg::front_type                   front_out
);

   logic [crg_pkg::ROW_W-1:0] rows [3];
   logic signed [crg_pkg::COEF_W-1:0] ca [3];
   logic signed [crg_pkg::COEF_W-1:0] cb [3];
   logic signed [crg_pkg::COEF_W-1:0] cc [3];

   logic [crg_pkg::OFF_W-1:0] off_x, off_y;
   logic signed [crg_pkg::W_W-1:0] wx_in, wy_in, wx_ff, wy_ff;
   logic signed [crg_pkg::PROD_W-1:0] pa_in [3], pb_in [3], pa_ff [3], pb_ff [3];
   logic signed [crg_pkg::D_W-1:0] d_in [3], d_ff [3];
   crg_pkg::front_type out_in, out_ff;
   logic v1_ff, v2_ff, v3_ff;

   assign rows[0] = row_x;
   assign rows[1] = row_y;
   assign rows[2] = row_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ca[i] = $signed(rows[i][0 +: crg_pkg::COEF_W]);
         cb[i] = $signed(rows[i][crg_pkg::COEF_W +: crg_pkg::COEF_W]);
         cc[i] = $signed(rows[i][2*crg_pkg::COEF_W +: crg_pkg::COEF_W]);
      end
   end

   // stage 1: w = (half << 13) - (2p+1)*ps
   always_comb begin
      off_x = crg_pkg::OFF_W'({px, 1'b1}) * crg_pkg::OFF_W'(ps);
      off_y = crg_pkg::OFF_W'({py, 1'b1}) * crg_pkg::OFF_W'(ps);
      wx_in = $signed(crg_pkg::W_W'({half_w, {crg_pkg::HALF_SHIFT{1'b0}}}))
            - $signed(crg_pkg::W_W'(off_x));
      wy_in = $signed(crg_pkg::W_W'({half_h, {crg_pkg::HALF_SHIFT{1'b0}}}))
            - $signed(crg_pkg::W_W'(off_y));
   end

   // stage 2: coefficient products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pa_in[i] = crg_pkg::PROD_W'(ca[i]) * crg_pkg::PROD_W'(wx_ff);
         pb_in[i] = crg_pkg::PROD_W'(cb[i]) * crg_pkg::PROD_W'(wy_ff);
      end
   end

   // stage 3: d = a*wx + b*wy - c*2^25
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = crg_pkg::D_W'(pa_ff[i]) + crg_pkg::D_W'(pb_ff[i])
                 - (crg_pkg::D_W'(cc[i]) <<< crg_pkg::Z_SHIFT);
      end
   end

   // stage 4: sign and magnitude
   always_comb begin
      out_in.valid = v3_ff;
      for (int i = 0; i < 3; i++) begin
         out_in.neg[i] = d_ff[i][crg_pkg::D_W-1];
         out_in.mag[i] = d_ff[i][crg_pkg::D_W-1] ? crg_pkg::MAG_W'(-d_ff[i])
                                                 : crg_pkg::MAG_W'(d_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= wx_in;
         wy_ff <= wy_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         d_ff  <= d_in;
      end
   end

   assign front_out = out_ff;

endmodule

// ===== rtl/crg_norm.sv =====
// Block scaling of the magnitudes and sum of squares (five stages).
`timescale 1ns / 1ps
module crg_norm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  crg_pkg::front_type          front_in,
   output crg_pkg::side_type           side_out,
   output logic [crg_pkg::SUM_W-1:0]   sum_out
);

   logic [crg_pkg::PAD_W-1:0] or_w;
   logic [crg_pkg::GRP_N-1:0] nz_in, nz_ff;
   logic [2:0] idx_in [crg_pkg::GRP_N];
   logic [2:0] idx_ff [crg_pkg::GRP_N];
   crg_pkg::front_type fa_ff, fb_ff;
   logic [crg_pkg::POS_W-1:0] pos_in, pos_ff;
   logic degb_in, degb_ff;
   crg_pkg::side_type sc_in, sc_ff, sd_ff, se_ff;
   logic [crg_pkg::SQ_W-1:0] sq_in [3], sq_ff [3];
   logic [crg_pkg::SUM_W-1:0] sum_in, sum_ff;

   // A: the leading one of the OR is the leading one of the largest magnitude
   always_comb begin
      or_w = crg_pkg::PAD_W'(front_in.mag[0] | front_in.mag[1] | front_in.mag[2]);
      for (int g = 0; g < crg_pkg::GRP_N; g++) begin
         nz_in[g]  = |or_w[g*8 +: 8];
         idx_in[g] = 3'd0;
         for (int b = 0; b < 8; b++) begin
            if (or_w[g*8+b]) idx_in[g] = 3'(b);
         end
      end
   end

   // B: highest nonzero group
   always_comb begin
      pos_in  = '0;
      for (int g = 0; g < crg_pkg::GRP_N; g++) begin
         if (nz_ff[g]) pos_in = crg_pkg::POS_W'(g*8) + crg_pkg::POS_W'(idx_ff[g]);
      end
      degb_in = ~|nz_ff;
   end

   // C: shift so that the top bit lands on NORM_MSB; right shifts truncate
   always_comb begin
      sc_in.valid = fb_ff.valid;
      sc_in.deg   = degb_ff;
      sc_in.neg   = fb_ff.neg;
      for (int i = 0; i < 3; i++) begin
         if (pos_ff >= crg_pkg::POS_W'(crg_pkg::NORM_MSB)) begin
            sc_in.m[i] = crg_pkg::NM_W'(fb_ff.mag[i]
                         >> (pos_ff - crg_pkg::POS_W'(crg_pkg::NORM_MSB)));
         end else begin
            sc_in.m[i] = crg_pkg::NM_W'(fb_ff.mag[i]
                         << (crg_pkg::POS_W'(crg_pkg::NORM_MSB) - pos_ff));
         end
      end
   end

   // D, E: squares, then their sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = crg_pkg::SQ_W'(sc_ff.m[i]) * crg_pkg::SQ_W'(sc_ff.m[i]);
      end
      sum_in = crg_pkg::SUM_W'(sq_ff[0]) + crg_pkg::SUM_W'(sq_ff[1])
             + crg_pkg::SUM_W'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fa_ff.valid <= 1'b0;
         fb_ff.valid <= 1'b0;
         sc_ff.valid <= 1'b0;
         sd_ff.valid <= 1'b0;
         se_ff.valid <= 1'b0;
      end else if (en) begin
         fa_ff <= front_in;
         fb_ff <= fa_ff;
         sc_ff <= sc_in;
         sd_ff <= sc_ff;
         se_ff <= sd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nz_ff   <= nz_in;
         idx_ff  <= idx_in;
         pos_ff  <= pos_in;
         degb_ff <= degb_in;
         sq_ff   <= sq_in;
         sum_ff  <= sum_in;
      end
   end

   assign side_out = se_ff;
   assign sum_out  = sum_ff;

endmodule

// ===== rtl/crg_sqrt.sv =====
// Integer square root, one root bit per pipeline stage.
`timescale 1ns / 1ps
module crg_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  crg_pkg::side_type           side_in,
   input  logic [crg_pkg::SUM_W-1:0]   sum_in,
   output crg_pkg::side_type           side_out,
   output logic [crg_pkg::ROOT_W-1:0]  root_out
);

   logic [crg_pkg::SUM_W-1:0]  rem_at  [crg_pkg::ROOT_W+1];
   logic [crg_pkg::ROOT_W-1:0] root_at [crg_pkg::ROOT_W+1];
   crg_pkg::side_type          side_at [crg_pkg::ROOT_W+1];
   logic [crg_pkg::SUM_W-1:0]  rem_ff  [crg_pkg::ROOT_W];
   logic [crg_pkg::ROOT_W-1:0] root_ff [crg_pkg::ROOT_W];
   crg_pkg::side_type          side_ff [crg_pkg::ROOT_W];

   assign rem_at[0]  = sum_in;
   assign root_at[0] = '0;
   assign side_at[0] = side_in;

   for (genvar s = 0; s < crg_pkg::ROOT_W; s++) begin : g_stage
      localparam int K = crg_pkg::ROOT_W - 1 - s;
      logic [crg_pkg::EXT_W-1:0]  rem_x, trial;
      logic [crg_pkg::SUM_W-1:0]  rem_in;
      logic [crg_pkg::ROOT_W-1:0] root_in;

      // (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k)
      always_comb begin
         rem_x = crg_pkg::EXT_W'(rem_at[s]);
         trial = (crg_pkg::EXT_W'(root_at[s]) << (K + 1))
               + (crg_pkg::EXT_W'(1) << (2 * K));
         if (rem_x >= trial) begin
            rem_in  = crg_pkg::SUM_W'(rem_x - trial);
            root_in = root_at[s] | (crg_pkg::ROOT_W'(1) << K);
         end else begin
            rem_in  = rem_at[s];
            root_in = root_at[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[s].valid <= 1'b0;
         end else if (en) begin
            side_ff[s] <= side_at[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
         end
      end

      assign rem_at[s+1]  = rem_ff[s];
      assign root_at[s+1] = root_ff[s];
      assign side_at[s+1] = side_ff[s];
   end

   assign side_out = side_at[crg_pkg::ROOT_W];
   assign root_out = root_at[crg_pkg::ROOT_W];

endmodule

// ===== rtl/crg_div.sv =====
// Rounding divide of each magnitude by the length, sign and output register.
`timescale 1ns / 1ps
module crg_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  crg_pkg::side_type           side_in,
   input  logic [crg_pkg::ROOT_W-1:0]  len_in,
   output crg_pkg::rsp_type            rsp_out
);

   logic [crg_pkg::DIV_W-1:0]  rem_at [crg_pkg::Q_W+1][3];
   logic [crg_pkg::Q_W-1:0]    q_at   [crg_pkg::Q_W+1][3];
   logic [crg_pkg::ROOT_W-1:0] len_at [crg_pkg::Q_W+1];
   crg_pkg::side_type          side_at[crg_pkg::Q_W+1];

   logic [crg_pkg::Q_W-1:0]  qv [3];
   logic [crg_pkg::QX_W-1:0] qs [3];
   crg_pkg::rsp_type out_in, out_ff;

   // numerator m*2^F + L/2 gives round half up of m*2^F/L
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_at[0][i] = (crg_pkg::DIV_W'(side_in.m[i]) << crg_pkg::DIR_FRAC_BITS)
                      + crg_pkg::DIV_W'(len_in >> 1);
         q_at[0][i]   = '0;
      end
   end
   assign len_at[0]  = len_in;
   assign side_at[0] = side_in;

   for (genvar s = 0; s < crg_pkg::Q_W; s++) begin : g_stage
      localparam int J = crg_pkg::DIR_FRAC_BITS - s;
      logic [crg_pkg::DIV_W-1:0] dv;
      logic [crg_pkg::DIV_W-1:0] rem_in [3];
      logic [crg_pkg::Q_W-1:0]   q_in   [3];
      logic [crg_pkg::DIV_W-1:0] rem_ff [3];
      logic [crg_pkg::Q_W-1:0]   q_ff   [3];
      logic [crg_pkg::ROOT_W-1:0] len_ff;
      crg_pkg::side_type          side_ff;

      always_comb begin
         dv = crg_pkg::DIV_W'(len_at[s]) << J;
         for (int i = 0; i < 3; i++) begin
            if (rem_at[s][i] >= dv) begin
               rem_in[i] = rem_at[s][i] - dv;
               q_in[i]   = q_at[s][i] | (crg_pkg::Q_W'(1) << J);
            end else begin
               rem_in[i] = rem_at[s][i];
               q_in[i]   = q_at[s][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff.valid <= 1'b0;
         end else if (en) begin
            side_ff <= side_at[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            len_ff <= len_at[s];
         end
      end

      assign rem_at[s+1]  = rem_ff;
      assign q_at[s+1]    = q_ff;
      assign len_at[s+1]  = len_ff;
      assign side_at[s+1] = side_ff;
   end

   always_comb begin
      out_in.valid = side_at[crg_pkg::Q_W].valid;
      out_in.deg   = side_at[crg_pkg::Q_W].deg;
      for (int i = 0; i < 3; i++) begin
         qv[i] = (q_at[crg_pkg::Q_W][i] > crg_pkg::DIR_ONE) ? crg_pkg::DIR_ONE
                                                            : q_at[crg_pkg::Q_W][i];
         qs[i] = side_at[crg_pkg::Q_W].neg[i] ? -crg_pkg::QX_W'(qv[i])
                                              : crg_pkg::QX_W'(qv[i]);
         out_in.dir[i] = side_at[crg_pkg::Q_W].deg ? '0 : qs[i][crg_pkg::OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_out = out_ff;

endmodule

// ===== rtl/camera_ray_generator.sv =====
// Top level of the pinhole camera primary ray generator.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   pixel_x, pixel_y
//   rsp      out        rsp_valid/rsp_stall   origin_x/y/z, dir_x/y/z, degenerate
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One request enters per cycle while req_stall is low; its ray passes through the
// 4 transform + 5 scaling + 31 square-root + 15 divide stages and the output register.
// The square-root stages, one root bit each, make up most of the pipeline.
// A stalled response freezes the whole pipeline; req_stall follows at once.
// Reset (synchronous) empties the pipeline and loads the identity transform.
`timescale 1ns / 1ps
module camera_ray_generator (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [crg_pkg::PIXEL_COORD_BITS-1:0] req_pixel_x,
   input  logic [crg_pkg::PIXEL_COORD_BITS-1:0] req_pixel_y,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [crg_pkg::OUT_W-1:0]     rsp_origin_x,
   output logic signed [crg_pkg::OUT_W-1:0]     rsp_origin_y,
   output logic signed [crg_pkg::OUT_W-1:0]     rsp_origin_z,
   output logic signed [crg_pkg::OUT_W-1:0]     rsp_dir_x,
   output logic signed [crg_pkg::OUT_W-1:0]     rsp_dir_y,
   output logic signed [crg_pkg::OUT_W-1:0]     rsp_dir_z,
   output logic                                 rsp_degenerate,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [crg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [crg_pkg::CSR_DATA_W-1:0]       csr_data
);

   // configuration; the user must write it only with the pipeline drained (not enforced)
   logic [crg_pkg::ROW_W-1:0]  row_x_ff, row_y_ff, row_z_ff;
   logic [crg_pkg::HALF_W-1:0] half_w_ff, half_h_ff;
   logic [crg_pkg::PS_W-1:0]   ps_ff;

   logic en;
   crg_pkg::front_type front;
   crg_pkg::side_type  side_n, side_s;
   logic [crg_pkg::SUM_W-1:0]  sum;
   logic [crg_pkg::ROOT_W-1:0] len;
   crg_pkg::rsp_type   rsp;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff  <= crg_pkg::ROW_X_RESET;
         row_y_ff  <= crg_pkg::ROW_Y_RESET;
         row_z_ff  <= crg_pkg::ROW_Z_RESET;
         half_w_ff <= crg_pkg::HALF_RESET;
         half_h_ff <= crg_pkg::HALF_RESET;
         ps_ff     <= crg_pkg::PS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            crg_pkg::CSR_ROW_X:       row_x_ff  <= csr_data;
            crg_pkg::CSR_ROW_Y:       row_y_ff  <= csr_data;
            crg_pkg::CSR_ROW_Z:       row_z_ff  <= csr_data;
            crg_pkg::CSR_HALF_WIDTH:  half_w_ff <= csr_data[crg_pkg::HALF_W-1:0];
            crg_pkg::CSR_HALF_HEIGHT: half_h_ff <= csr_data[crg_pkg::HALF_W-1:0];
            crg_pkg::CSR_PIXEL_SIZE:  ps_ff     <= csr_data[crg_pkg::PS_W-1:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   // global advance: everything moves unless the output holds an untaken ray
   assign en        = !(rsp.valid && rsp_stall);
   assign req_stall = !en;

   crg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .px        (req_pixel_x),
      .py        (req_pixel_y),
      .row_x     (row_x_ff),
      .row_y     (row_y_ff),
      .row_z     (row_z_ff),
      .half_w    (half_w_ff),
      .half_h    (half_h_ff),
      .ps        (ps_ff),
      .front_out (front)
   );

   crg_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .front_in (front),
      .side_out (side_n),
      .sum_out  (sum)
   );

   crg_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .side_in  (side_n),
      .sum_in   (sum),
      .side_out (side_s),
      .root_out (len)
   );

   crg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .side_in (side_s),
      .len_in  (len),
      .rsp_out (rsp)
   );

   // origin is the translation column; the user must keep config steady while rays are in flight (not enforced)
   assign rsp_origin_x   = $signed(row_x_ff[crg_pkg::TRANS_LSB +: crg_pkg::OUT_W]);
   assign rsp_origin_y   = $signed(row_y_ff[crg_pkg::TRANS_LSB +: crg_pkg::OUT_W]);
   assign rsp_origin_z   = $signed(row_z_ff[crg_pkg::TRANS_LSB +: crg_pkg::OUT_W]);
   assign rsp_valid      = rsp.valid;
   assign rsp_degenerate = rsp.deg;
   assign rsp_dir_x      = $signed(rsp.dir[0]);
   assign rsp_dir_y      = $signed(rsp.dir[1]);
   assign rsp_dir_z      = $signed(rsp.dir[2]);

   // degenerate rays carry a zero direction
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> (rsp_dir_x == '0 && rsp_dir_y == '0 && rsp_dir_z == '0))
      else $error("degenerate ray with nonzero direction");

   // scaled largest component keeps a normalized ray away from zero
   a_dir_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> (rsp_dir_x != '0 || rsp_dir_y != '0 || rsp_dir_z != '0))
      else $error("normalized ray with zero direction");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule
